// ===== design/sse_pkg.sv =====
// shared types, sizes and sequencer states of the shell sort engine
// no dependencies; used by the channel interfaces and the core
package sse_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PASS,
      ST_HOLD_RD,
      ST_HOLD_CAP,
      ST_CMP_RD,
      ST_CMP,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

endpackage

// ===== design/sse_if.sv =====
// valid/ready channel interfaces for sample beats in and sorted beats out
// depends on sse_pkg
interface sse_req_if;
   logic              valid;
   logic              ready;
   sse_pkg::data_type sample_value;
   logic              batch_end;

   modport source (output valid, output sample_value, output batch_end, input ready);
   modport sink   (input valid, input sample_value, input batch_end, output ready);
endinterface

interface sse_rsp_if;
   logic              valid;
   logic              ready;
   sse_pkg::data_type sorted_value;
   logic              final_flag;
   logic              overflow_flag;

   modport source (output valid, output sorted_value, output final_flag,
                   output overflow_flag, input ready);
   modport sink   (input valid, input sorted_value, input final_flag,
                   input overflow_flag, output ready);
endinterface

// ===== design/shell_sort_engine_core.sv =====
// Batch sorter: values stream in one per beat into a local store of
// sse_pkg::DEPTH entries; the beat carrying batch_end closes the batch. The store is then
// sorted ascending (signed) by Shell sort with gaps n/2, n/4, ... 1, and the n values stream
// out in order, the last one with final_flag set; overflow_flag is set on every output beat
// if values beyond the store depth were dropped. Input is not taken while sorting or
// emitting. All work goes through the one store memory (one write, one read port) and one
// signed comparator: an insertion step reads and captures its element, reads and compares
// each neighbour a gap below, shifting it up while greater, then writes the held value into
// place; ST_PASS opens each gap pass and ends the sort; output reads then offers each value.
// depends on sse_pkg, sse_if and sse_ram
module shell_sort_engine_core (
   input  logic      clock,
   input  logic      reset,
   sse_req_if.sink   req_ch,
   sse_rsp_if.source rsp_ch
);

   sse_pkg::state_type state_ff, state_in;
   sse_pkg::cnt_type   fill_ff, fill_in;
   logic               drop_ff, drop_in;
   sse_pkg::addr_type  gap_ff, gap_in;
   sse_pkg::addr_type  idx_ff, idx_in;
   sse_pkg::addr_type  pos_ff, pos_in;
   sse_pkg::data_type  hold_ff, hold_in;

   logic                      wr_en;
   sse_pkg::addr_type         wr_addr;
   logic [sse_pkg::DATA_W-1:0] wr_data;
   sse_pkg::addr_type         rd_addr;
   logic [sse_pkg::DATA_W-1:0] rd_data;

   logic              req_beat;
   logic              rsp_beat;
   logic              store_full;
   sse_pkg::cnt_type  fill_inc;
   sse_pkg::cnt_type  idx_next;
   logic              more_idx;
   logic              pos_ge_gap;
   logic              shift_up;
   logic              last_out;

   // store
   sse_ram #(
      .WIDTH (sse_pkg::DATA_W),
      .DEPTH (sse_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare and index arithmetic
   assign req_beat   = req_ch.valid && req_ch.ready;
   assign rsp_beat   = rsp_ch.valid && rsp_ch.ready;
   assign store_full = (fill_ff == sse_pkg::CNT_W'(sse_pkg::DEPTH));
   assign fill_inc   = store_full ? fill_ff : fill_ff + 1'b1;
   assign idx_next   = sse_pkg::CNT_W'(idx_ff) + 1'b1;
   assign more_idx   = (idx_next < fill_ff);
   assign last_out   = (idx_next == fill_ff);
   assign pos_ge_gap = (pos_ff >= gap_ff);
   assign shift_up   = ($signed(rd_data) > hold_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sse_pkg::ST_LOAD: begin
            if (req_beat && req_ch.batch_end) begin
               state_in = sse_pkg::ST_PASS;
            end
         end
         sse_pkg::ST_PASS: begin
            if (gap_ff == '0) begin
               state_in = sse_pkg::ST_EMIT_RD;
            end else begin
               state_in = sse_pkg::ST_HOLD_RD;
            end
         end
         sse_pkg::ST_HOLD_RD:  state_in = sse_pkg::ST_HOLD_CAP;
         sse_pkg::ST_HOLD_CAP: state_in = sse_pkg::ST_CMP_RD;
         sse_pkg::ST_CMP_RD: begin
            if (pos_ge_gap) begin
               state_in = sse_pkg::ST_CMP;
            end else begin
               state_in = sse_pkg::ST_PLACE;
            end
         end
         sse_pkg::ST_CMP: begin
            if (shift_up) begin
               state_in = sse_pkg::ST_CMP_RD;
            end else begin
               state_in = sse_pkg::ST_PLACE;
            end
         end
         sse_pkg::ST_PLACE: begin
            if (more_idx) begin
               state_in = sse_pkg::ST_HOLD_RD;
            end else begin
               state_in = sse_pkg::ST_PASS;
            end
         end
         sse_pkg::ST_EMIT_RD: state_in = sse_pkg::ST_EMIT;
         sse_pkg::ST_EMIT: begin
            if (rsp_beat) begin
               if (last_out) begin
                  state_in = sse_pkg::ST_LOAD;
               end else begin
                  state_in = sse_pkg::ST_EMIT_RD;
               end
            end
         end
         default: state_in = sse_pkg::ST_LOAD;
      endcase
   end

   // memory port and handshake outputs
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = rd_data;
      rd_addr      = idx_ff;
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      unique case (state_ff)
         sse_pkg::ST_LOAD: begin
            req_ch.ready = 1'b1;
            wr_en        = req_beat && !store_full;
            wr_addr      = sse_pkg::ADDR_W'(fill_ff);
            wr_data      = req_ch.sample_value;
         end
         sse_pkg::ST_CMP_RD: begin
            rd_addr = pos_ff - gap_ff;
         end
         sse_pkg::ST_CMP: begin
            wr_en = shift_up;
         end
         sse_pkg::ST_PLACE: begin
            wr_en   = 1'b1;
            wr_data = hold_ff;
         end
         sse_pkg::ST_EMIT: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.sorted_value  = $signed(rd_data);
   assign rsp_ch.final_flag    = last_out;
   assign rsp_ch.overflow_flag = drop_ff;

   // datapath register next values
   always_comb begin
      fill_in = fill_ff;
      drop_in = drop_ff;
      gap_in  = gap_ff;
      idx_in  = idx_ff;
      pos_in  = pos_ff;
      hold_in = hold_ff;
      unique case (state_ff)
         sse_pkg::ST_LOAD: begin
            if (req_beat) begin
               fill_in = fill_inc;
               if (store_full) begin
                  drop_in = 1'b1;
               end
               gap_in = sse_pkg::ADDR_W'(fill_inc >> 1);
            end
         end
         sse_pkg::ST_PASS: begin
            idx_in = (gap_ff == '0) ? '0 : gap_ff;
         end
         sse_pkg::ST_HOLD_CAP: begin
            hold_in = $signed(rd_data);
            pos_in  = idx_ff;
         end
         sse_pkg::ST_CMP: begin
            if (shift_up) begin
               pos_in = pos_ff - gap_ff;
            end
         end
         sse_pkg::ST_PLACE: begin
            if (more_idx) begin
               idx_in = sse_pkg::ADDR_W'(idx_next);
            end else begin
               gap_in = gap_ff >> 1;
            end
         end
         sse_pkg::ST_EMIT: begin
            if (rsp_beat) begin
               if (last_out) begin
                  fill_in = '0;
                  drop_in = 1'b0;
               end else begin
                  idx_in = sse_pkg::ADDR_W'(idx_next);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sse_pkg::ST_LOAD;
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      gap_ff  <= gap_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      hold_ff <= hold_in;
   end

`ifndef NO_ASSERTIONS
   // never taking samples while a sorted beat is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while output valid");

   // fill count stays within the store
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= sse_pkg::CNT_W'(sse_pkg::DEPTH))
      else $error("fill count beyond store depth");

   // a dropped value only happens with a full store
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> store_full)
      else $error("drop mark set without full store");

   // after the final beat the block is empty and ready for the next batch
   a_final_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_ch.final_flag) |=> (req_ch.ready && fill_ff == '0 && !drop_ff))
      else $error("batch not cleared after final beat");
`endif

endmodule

// ===== design/sse_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== dv/shell_sort_engine_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of shell_sort_engine_core: batches of signed samples in, sorted beats out
// depends on sse_pkg, sse_if and the design sources of shell_sort_engine_core
module shell_sort_engine_core_tb;

   localparam int unsigned       CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned       DRAIN_CYCLES = 64;
   localparam int unsigned       PHASE_ITEMS  = 90;
   localparam sse_pkg::data_type DATA_MAX     = sse_pkg::data_type'(32'h7fff_ffff);
   localparam sse_pkg::data_type DATA_MIN     = sse_pkg::data_type'(32'h8000_0000);

   // idling per phase: none, sender only, receiver only, both
   localparam int unsigned SEND_IDLE_PCT[4] = '{0, 48, 0, 28};
   localparam int unsigned STALL_PCT[4]     = '{0, 0, 48, 28};

   typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_EXTREME, PAT_FALLING, PAT_RISING} pattern_type;

   typedef struct packed {
      sse_pkg::data_type value;
      logic              final_flag;
      logic              overflow_flag;
   } sorted_beat_type;

   // holds the batch being gathered and the sorted beats still owed by the block
   class sorted_batch_board;
      sse_pkg::data_type held[$];
      logic              dropped = 1'b0;
      sorted_beat_type   sorted_due[$];
      int unsigned       mismatches = 0;
      int unsigned       beats_checked = 0;

      function void take_sample(sse_pkg::data_type v, logic last);
         int                n;
         int                gap;
         int                i;
         int                pos;
         sse_pkg::data_type hold;
         sorted_beat_type   beat;
         if (held.size() < sse_pkg::DEPTH) held.push_back(v);
         else dropped = 1'b1;
         if (!last) return;
         // gapped insertion passes with halving gaps, signed order
         n = held.size();
         for (gap = n / 2; gap > 0; gap = gap / 2) begin
            for (i = gap; i < n; i++) begin
               hold = held[i];
               pos  = i;
               while (pos >= gap && held[pos-gap] > hold) begin
                  held[pos] = held[pos-gap];
                  pos -= gap;
               end
               held[pos] = hold;
            end
         end
         for (i = 0; i < n; i++) begin
            beat.value         = held[i];
            beat.final_flag    = (i == n - 1);
            beat.overflow_flag = dropped;
            sorted_due.push_back(beat);
         end
         held.delete();
         dropped = 1'b0;
      endfunction

      function void match_sorted(sse_pkg::data_type v, logic fin, logic ovf);
         sorted_beat_type want;
         beats_checked++;
         if (sorted_due.size() == 0) begin
            $display("%0t: sorted beat with nothing owed: expected none, actual %0d/%b/%b",
                     $time, v, fin, ovf);
            mismatches++;
            return;
         end
         want = sorted_due.pop_front();
         if (v !== want.value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time, want.value, v);
            mismatches++;
         end
         if (fin !== want.final_flag) begin
            $display("%0t: final_flag expected %b actual %b", $time, want.final_flag, fin);
            mismatches++;
         end
         if (ovf !== want.overflow_flag) begin
            $display("%0t: overflow_flag expected %b actual %b", $time, want.overflow_flag, ovf);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   sse_req_if req_bus ();
   sse_rsp_if rsp_bus ();

   sorted_batch_board board = new;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned batches_sent = 0;
   int unsigned samples_sent = 0;
   int unsigned overflow_batches = 0;

   shell_sort_engine_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, updated on the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // check every accepted sorted beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.match_sorted(rsp_bus.sorted_value, rsp_bus.final_flag, rsp_bus.overflow_flag);
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d sorted beats still owed",
               cycle_count, board.sorted_due.size());
      $display("shell_sort_engine_core_tb: done, errors");
      $finish;
   end

   // send one batch, batch_end on its last beat; entered and left on a falling edge
   task automatic send_batch(input sse_pkg::data_type vals[$]);
      for (int k = 0; k < vals.size(); k++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
         req_bus.valid        <= 1'b1;
         req_bus.sample_value <= vals[k];
         req_bus.batch_end    <= (k == vals.size() - 1);
         do @(posedge clock); while (req_bus.ready !== 1'b1);
         board.take_sample(vals[k], k == vals.size() - 1);
         @(negedge clock);
      end
      samples_sent += vals.size();
      batches_sent++;
      if (vals.size() > sse_pkg::DEPTH) overflow_batches++;
   endtask

   initial begin
      sse_pkg::data_type vals[$];
      sse_pkg::data_type base;
      pattern_type       pattern;
      int                count;
      int                phase_items;
      int                pick;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.sample_value = '0;
      req_bus.batch_end    = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single value, pair, extremes, equal values, falling run
      vals = '{DATA_MIN};
      send_batch(vals);
      vals = '{DATA_MAX, DATA_MIN};
      send_batch(vals);
      vals = '{0, -1, 1, DATA_MAX, DATA_MIN, DATA_MAX - 1, DATA_MIN + 1,
               sse_pkg::data_type'(32'h5555_5555), sse_pkg::data_type'(32'haaaa_aaaa)};
      send_batch(vals);
      vals = '{7, 7, -7, 7, -7};
      send_batch(vals);
      vals = '{4, 3, 2, 1, 0, -1};
      send_batch(vals);

      // random batches over the four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = SEND_IDLE_PCT[phase];
         stall_pct     = STALL_PCT[phase];
         phase_items   = 0;
         while (phase_items < PHASE_ITEMS) begin
            // one full store and one overflowing batch, the rest mostly short
            if (phase == 1 && phase_items == 0) count = sse_pkg::DEPTH;
            else if (phase == 3 && phase_items == 0)
               count = sse_pkg::DEPTH + 1 + $urandom_range(4);
            else if ($urandom_range(99) < 75) count = $urandom_range(12, 1);
            else count = $urandom_range(40, 13);
            pattern = pattern_type'($urandom_range(PAT_RISING));
            base    = sse_pkg::data_type'($urandom);
            vals.delete();
            for (int k = 0; k < count; k++) begin
               case (pattern)
                  PAT_NARROW:  vals.push_back(sse_pkg::data_type'($urandom_range(6)) - 3);
                  PAT_EXTREME: begin
                     pick = $urandom_range(4);
                     case (pick)
                        0:       vals.push_back(DATA_MIN);
                        1:       vals.push_back(DATA_MAX);
                        2:       vals.push_back(0);
                        3:       vals.push_back(-1);
                        default: vals.push_back(1);
                     endcase
                  end
                  PAT_FALLING: vals.push_back(base - k);
                  PAT_RISING:  vals.push_back(base + k);
                  default:     vals.push_back(sse_pkg::data_type'($urandom));
               endcase
            end
            send_batch(vals);
            phase_items += count;
         end
      end
      req_bus.valid <= 1'b0;

      // drain
      while (board.sorted_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d batches, %0d samples sent (%0d batches over depth)",
               batches_sent, samples_sent, overflow_batches);
      $display("%0d sorted beats checked, %0d mismatches", board.beats_checked, board.mismatches);
      if (board.mismatches == 0 && board.sorted_due.size() == 0) begin
         $display("shell_sort_engine_core_tb: done, clean");
      end else begin
         $display("shell_sort_engine_core_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sse_pkg.sv
design/sse_if.sv
design/sse_ram.sv
design/shell_sort_engine_core.sv
dv/shell_sort_engine_core_tb.sv
